// ----- sv/confusion_matrix_stats_unit_assert.svh -----
// Assertion macros for the checker file of the confusion matrix block.
// The enclosing module must provide clk and rst_n.
`ifndef CONFUSION_MATRIX_STATS_UNIT_ASSERT_SVH
`define CONFUSION_MATRIX_STATS_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CMS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("confusion matrix check failed");

// Consequent must hold in the cycle after the antecedent.
`define CMS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("confusion matrix check failed");

`endif

// ----- sv/cms_pkg.sv -----
package cms_pkg;

    localparam int NUM_CLASSES = 16;
    localparam int COUNT_WIDTH = 32;

    localparam int CELLS  = NUM_CLASSES * NUM_CLASSES;
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WALK_W = $clog2(2 * NUM_CLASSES);
    localparam int SUM_W  = COUNT_WIDTH + CLS_W;
    localparam int TOT_W  = COUNT_WIDTH + ADDR_W;

    typedef enum logic [1:0] {
        MODE_RECORD = 2'd0,
        MODE_STATS  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    function automatic logic [CLS_W-1:0] to_cls(input logic [3:0] c);
        return CLS_W'(c);
    endfunction

    function automatic logic cls_ok(input logic [3:0] c);
        return 32'(c) < 32'(NUM_CLASSES);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CLS_W-1:0] r,
                                                    input logic [CLS_W-1:0] c);
        return ADDR_W'(32'(r) * 32'(NUM_CLASSES) + 32'(c));
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [39:0] sat40(input logic [63:0] v);
        return (v > 64'h0000_00FF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : v[39:0];
    endfunction

endpackage

// ----- sv/confusion_matrix_stats_unit.sv -----
// From accepted request to result valid, a record passes ST_REC_RD and ST_REC_WR,
// a cell read passes ST_CELL_RD, and statistics pass ST_WALK, one matrix read per cycle
// over the queried row and column through the single memory port, then ST_DRAIN and ST_UNION.
// A new request can be taken from the cycle after the previous result is loaded.
// After reset the block clears the matrix with in_stall high.
module confusion_matrix_stats_unit
    import cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [3:0]  true_class,
    input  logic [3:0]  predicted_class,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] true_pos,
    output logic [39:0] false_pos,
    output logic [39:0] false_neg,
    output logic [39:0] true_neg,
    output logic [39:0] row_total,
    output logic [39:0] column_total,
    output logic [39:0] grand_total,
    output logic [31:0] cell_value
);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_CLEAR   = 9'b000000010,
        ST_REC_RD  = 9'b000000100,
        ST_REC_WR  = 9'b000001000,
        ST_CELL_RD = 9'b000010000,
        ST_WALK    = 9'b000100000,
        ST_DRAIN   = 9'b001000000,
        ST_UNION   = 9'b010000000,
        ST_FINISH  = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_ROW  = 2'd1,
        KIND_COL  = 2'd2
    } kind_t;

    state_t state_reg, state_next;
    kind_t  kind_reg, kind_next;
    logic   diag_hit_reg, diag_hit_next;

    logic [ADDR_W-1:0] clr_reg;
    logic [WALK_W-1:0] walk_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              out_valid_reg;

    mode_t             mode_reg;
    logic [CLS_W-1:0]  tc_reg;
    logic [CLS_W-1:0]  pc_reg;
    logic              tc_ok_reg;
    logic              pc_ok_reg;
    logic [SUM_W-1:0]  row_acc_reg;
    logic [SUM_W-1:0]  col_acc_reg;
    logic [COUNT_WIDTH-1:0] diag_reg;
    logic [SUM_W:0]    union_reg;

    logic [31:0] true_pos_reg, cell_value_reg;
    logic [39:0] false_pos_reg, false_neg_reg, true_neg_reg;
    logic [39:0] row_total_reg, column_total_reg, grand_total_reg;

    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_addr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] mem_rdata;

    logic accept;
    logic walk_row;
    logic walk_last;
    logic cell_full;
    logic load_out;
    logic [CLS_W-1:0] walk_cls;

    cms_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (CELLS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign walk_row  = walk_reg < WALK_W'(NUM_CLASSES);
    assign walk_last = walk_reg == WALK_W'(2 * NUM_CLASSES - 1);
    assign walk_cls  = walk_row ? CLS_W'(walk_reg)
                                : CLS_W'(walk_reg - WALK_W'(NUM_CLASSES));
    assign cell_full = mem_rdata == {COUNT_WIDTH{1'b1}};
    assign load_out  = (state_reg == ST_FINISH) && !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next    = state_reg;
        mem_we        = 1'b0;
        mem_addr      = cell_addr(tc_reg, pc_reg);
        mem_wdata     = mem_rdata + COUNT_WIDTH'(1);
        kind_next     = KIND_NONE;
        diag_hit_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_RECORD:
                            state_next = (cls_ok(true_class) && cls_ok(predicted_class))
                                         ? ST_REC_RD : ST_FINISH;
                        MODE_STATS:
                            state_next = cls_ok(true_class) ? ST_WALK : ST_UNION;
                        MODE_READ:
                            state_next = (cls_ok(true_class) && cls_ok(predicted_class))
                                         ? ST_CELL_RD : ST_FINISH;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = '0;
                if (clr_reg == ADDR_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REC_RD:
            begin
                state_next = ST_REC_WR;
            end
            ST_REC_WR:
            begin
                // A full counter is left as it is.
                mem_we     = !cell_full;
                state_next = ST_FINISH;
            end
            ST_CELL_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_WALK:
            begin
                // The row is walked first, then the column; the diagonal is taken
                // from the row pass.
                mem_addr      = walk_row ? cell_addr(tc_reg, walk_cls)
                                         : cell_addr(walk_cls, tc_reg);
                kind_next     = walk_row ? KIND_ROW : KIND_COL;
                diag_hit_next = walk_row && (walk_cls == tc_reg);
                if (walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UNION;
            end
            ST_UNION:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            kind_reg      <= KIND_NONE;
            diag_hit_reg  <= 1'b0;
            clr_reg       <= '0;
            walk_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            diag_hit_reg <= diag_hit_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (accept)
            begin
                walk_reg <= '0;
            end
            else if (state_reg == ST_WALK)
            begin
                walk_reg <= walk_reg + WALK_W'(1);
            end
            if (state_reg == ST_REC_WR && !cell_full)
            begin
                total_reg <= total_reg + TOT_W'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode_t'(mode);
            tc_reg      <= to_cls(true_class);
            pc_reg      <= to_cls(predicted_class);
            tc_ok_reg   <= cls_ok(true_class);
            pc_ok_reg   <= cls_ok(predicted_class);
            row_acc_reg <= '0;
            col_acc_reg <= '0;
            diag_reg    <= '0;
        end
        else
        begin
            if (kind_reg == KIND_ROW)
            begin
                row_acc_reg <= row_acc_reg + SUM_W'(mem_rdata);
            end
            if (kind_reg == KIND_COL)
            begin
                col_acc_reg <= col_acc_reg + SUM_W'(mem_rdata);
            end
            if (diag_hit_reg)
            begin
                diag_reg <= mem_rdata;
            end
        end
        if (state_reg == ST_UNION)
        begin
            union_reg <= (SUM_W + 1)'(row_acc_reg) + (SUM_W + 1)'(col_acc_reg)
                       - (SUM_W + 1)'(diag_reg);
        end
        if (load_out)
        begin
            if (mode_reg == MODE_STATS)
            begin
                true_pos_reg     <= sat32(64'(diag_reg));
                false_pos_reg    <= sat40(64'(col_acc_reg - SUM_W'(diag_reg)));
                false_neg_reg    <= sat40(64'(row_acc_reg - SUM_W'(diag_reg)));
                true_neg_reg     <= sat40(64'(total_reg) - 64'(union_reg));
                row_total_reg    <= sat40(64'(row_acc_reg));
                column_total_reg <= sat40(64'(col_acc_reg));
                grand_total_reg  <= sat40(64'(total_reg));
            end
            else
            begin
                true_pos_reg     <= '0;
                false_pos_reg    <= '0;
                false_neg_reg    <= '0;
                true_neg_reg     <= '0;
                row_total_reg    <= '0;
                column_total_reg <= '0;
                grand_total_reg  <= '0;
            end
            if (mode_reg == MODE_READ && tc_ok_reg && pc_ok_reg)
            begin
                cell_value_reg <= sat32(64'(mem_rdata));
            end
            else
            begin
                cell_value_reg <= '0;
            end
        end
    end

    assign true_pos     = true_pos_reg;
    assign false_pos    = false_pos_reg;
    assign false_neg    = false_neg_reg;
    assign true_neg     = true_neg_reg;
    assign row_total    = row_total_reg;
    assign column_total = column_total_reg;
    assign grand_total  = grand_total_reg;
    assign cell_value   = cell_value_reg;

endmodule

// ----- sv/cms_ram.sv -----
module cms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read-before-write, registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/cms_checker.sv -----
`include "confusion_matrix_stats_unit_assert.svh"

module cms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] true_pos,
    input logic [39:0] false_pos,
    input logic [39:0] false_neg,
    input logic [39:0] true_neg,
    input logic [39:0] row_total,
    input logic [39:0] column_total,
    input logic [39:0] grand_total,
    input logic [31:0] cell_value
);

    logic [303:0] held_data;
    logic         row_sums_ok;
    logic         col_sums_ok;

    assign held_data   = {true_pos, false_pos, false_neg, true_neg,
                          row_total, column_total, grand_total, cell_value};
    assign row_sums_ok = (row_total <= grand_total) && (false_neg <= row_total)
                         && (true_neg <= grand_total);
    assign col_sums_ok = (column_total <= grand_total) && (false_pos <= column_total);

    // The block works on one request at a time.
    `CMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    `CMS_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(held_data))

    // A cell read reports no statistics.
    `CMS_ASSERT_NOW(a_mode_exclusive, out_valid && cell_value != 32'd0, true_pos == 32'd0)

    // Partial sums never exceed the sums they are part of.
    `CMS_ASSERT_NOW(a_row_sums, out_valid, row_sums_ok)

    `CMS_ASSERT_NOW(a_col_sums, out_valid, col_sums_ok)

endmodule

bind confusion_matrix_stats_unit cms_checker u_cms_checker (.*);
